[src/gdw_pkg.sv]
`default_nettype none

package gdw_pkg;

  // configuration register map (register index, byte address is 4 * index)
  localparam logic REG_GRID_COLUMNS = 1'b0;
  localparam logic REG_GRID_ROWS    = 1'b1;

  // raw register width and reset value
  localparam int          CFG_W     = 5;
  localparam logic [4:0]  CFG_RESET = 5'd10;

  // width of an effective grid size, holds any maximum up to 64
  localparam int SIZE_W = 8;

  // input operation codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // result event kinds
  localparam logic [1:0] EV_ENTER = 2'd0;
  localparam logic [1:0] EV_LEAVE = 2'd1;
  localparam logic [1:0] EV_NONE  = 2'd2;

  // effective grid size, already clamped to 1..maximum
  typedef struct packed {
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;
  } gdw_sizes_t;

endpackage

`default_nettype wire

[src/grid_dfs_tree_walker_core.sv]
`default_nettype none

// Depth-first walker over a 4-connected grid of up to MAX_COLUMNS x MAX_ROWS
// cells. Each input beat gives exactly one result beat. The visited bits live
// in a row-wide memory with one read port (one word per grid row) and the walk
// stack in a second memory; the top cell is kept in registers. An advance goes
// through three reads of the visited memory (the top cell's row and the rows
// above and below it), a decide step that pushes or pops, and an output step.
// A good start sweeps every row of the visited memory to clear it before its
// output step. A bad start or an advance with no walk goes straight to the
// output step. Any of these stretches while the output register still holds a
// beat that has not been taken; the input stalls until the walker is idle again.
module grid_dfs_tree_walker_core #(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [3:0]  in_start_column,
  input  wire logic [3:0]  in_start_row,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_cell_column,
  output logic [3:0]       out_cell_row,
  output logic [1:0]       out_event_kind,
  output logic             out_walk_done,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW         = $clog2(MAX_COLUMNS);
  localparam int RW         = $clog2(MAX_ROWS);
  localparam int CPAD       = 1 << CW;
  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int SAW        = $clog2(CELL_COUNT);
  localparam int DW         = $clog2(CELL_COUNT + 1);
  localparam int SW         = gdw_pkg::SIZE_W;

  // controller states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_RD_M = 3'd2;
  localparam logic [2:0] S_RD_P = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  gdw_pkg::gdw_sizes_t sizes;

  logic [2:0]             state_r, state_nxt;
  logic [RW-1:0]          clr_r, clr_nxt;
  logic [CW-1:0]          top_c_r, top_c_nxt;
  logic [RW-1:0]          top_row_r, top_row_nxt;
  logic [DW-1:0]          depth_r, depth_nxt;
  logic                   active_r, active_nxt;
  logic [MAX_COLUMNS-1:0] row_r_r, row_r_nxt;
  logic [MAX_COLUMNS-1:0] row_m_r, row_m_nxt;
  logic [3:0]             res_c_r, res_c_nxt;
  logic [3:0]             res_row_r, res_row_nxt;
  logic [1:0]             res_kind_r, res_kind_nxt;
  logic                   res_done_r, res_done_nxt;
  logic                   reload_r, reload_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [3:0]             out_c_r, out_c_nxt;
  logic [3:0]             out_row_r, out_row_nxt;
  logic [1:0]             out_kind_r, out_kind_nxt;
  logic                   out_done_r, out_done_nxt;

  // memory ports
  logic                   vis_wr_en, vis_rd_en;
  logic [RW-1:0]          vis_wr_addr, vis_rd_addr;
  logic [MAX_COLUMNS-1:0] vis_wr_data, vis_rd_data;
  logic                   stk_wr_en, stk_rd_en;
  logic [SAW-1:0]         stk_wr_addr, stk_rd_addr;
  logic [CW+RW-1:0]       stk_wr_data, stk_rd_data;

  // start cell
  logic [SW-1:0]          sc8, sr8;
  logic [CW-1:0]          sc_w;
  logic [RW-1:0]          sr_w;
  logic                   start_bad;
  logic                   in_beat;

  // neighbor checks
  logic [SW-1:0]          c8, r8;
  logic [CPAD-1:0]        row_r_pad, row_m_pad, row_p_pad;
  logic [CW-1:0]          c_inc, c_dec;
  logic [RW-1:0]          r_inc, r_dec;
  logic                   ok0, ok1, ok2, ok3;
  logic                   fr0, fr1, fr2, fr3;
  logic                   found;
  logic [CW-1:0]          n_c;
  logic [RW-1:0]          n_row;
  logic [MAX_COLUMNS-1:0] n_old;
  logic [DW-1:0]          depth_dec, depth_dec2;
  logic                   slot_free;

  assign pready = 1'b1;

  gdw_cfg #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .sizes   (sizes)
  );

  gdw_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_vis_ram (
    .clk     (clk),
    .wr_en   (vis_wr_en),
    .wr_addr (vis_wr_addr),
    .wr_data (vis_wr_data),
    .rd_en   (vis_rd_en),
    .rd_addr (vis_rd_addr),
    .rd_data (vis_rd_data)
  );

  gdw_ram #(
    .WIDTH (CW + RW),
    .DEPTH (CELL_COUNT)
  ) u_stk_ram (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_beat  = in_valid && !in_stall;

  // start cell bounds and truncation to grid coordinates
  assign sc8       = SW'(in_start_column);
  assign sr8       = SW'(in_start_row);
  assign sc_w      = sc8[CW-1:0];
  assign sr_w      = sr8[RW-1:0];
  assign start_bad = (sc8 >= sizes.cols) || (sr8 >= sizes.rows);

  // neighbor candidates of the top cell in the order +x, -y, -x, +y
  assign c8        = SW'(top_c_r);
  assign r8        = SW'(top_row_r);
  assign c_inc     = top_c_r + CW'(1);
  assign c_dec     = top_c_r - CW'(1);
  assign r_inc     = top_row_r + RW'(1);
  assign r_dec     = top_row_r - RW'(1);
  assign row_r_pad = CPAD'(row_r_r);
  assign row_m_pad = CPAD'(row_m_r);
  assign row_p_pad = CPAD'(vis_rd_data);

  assign ok0 = (c8 + SW'(1)) < sizes.cols;
  assign ok1 = (top_row_r != '0);
  assign ok2 = (top_c_r != '0);
  assign ok3 = (r8 + SW'(1)) < sizes.rows;

  assign fr0 = ok0 && !row_r_pad[c_inc];
  assign fr1 = ok1 && !row_m_pad[top_c_r];
  assign fr2 = ok2 && !row_r_pad[c_dec];
  assign fr3 = ok3 && !row_p_pad[top_c_r];
  assign found = fr0 || fr1 || fr2 || fr3;

  always_comb begin
    if (fr0) begin
      n_c   = c_inc;
      n_row = top_row_r;
      n_old = row_r_r;
    end else if (fr1) begin
      n_c   = top_c_r;
      n_row = r_dec;
      n_old = row_m_r;
    end else if (fr2) begin
      n_c   = c_dec;
      n_row = top_row_r;
      n_old = row_r_r;
    end else begin
      n_c   = top_c_r;
      n_row = r_inc;
      n_old = vis_rd_data;
    end
  end

  assign depth_dec  = depth_r - DW'(1);
  assign depth_dec2 = depth_r - DW'(2);
  assign slot_free  = !out_valid_r || !out_stall;

  // controller
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    top_c_nxt    = top_c_r;
    top_row_nxt  = top_row_r;
    depth_nxt    = depth_r;
    active_nxt   = active_r;
    row_r_nxt    = row_r_r;
    row_m_nxt    = row_m_r;
    res_c_nxt    = res_c_r;
    res_row_nxt  = res_row_r;
    res_kind_nxt = res_kind_r;
    res_done_nxt = res_done_r;
    reload_nxt   = reload_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_c_nxt    = out_c_r;
    out_row_nxt  = out_row_r;
    out_kind_nxt = out_kind_r;
    out_done_nxt = out_done_r;

    vis_wr_en    = 1'b0;
    vis_wr_addr  = clr_r;
    vis_wr_data  = '0;
    vis_rd_en    = 1'b0;
    vis_rd_addr  = top_row_r;
    stk_wr_en    = 1'b0;
    stk_wr_addr  = depth_r[SAW-1:0];
    stk_wr_data  = {n_row, n_c};
    stk_rd_en    = 1'b0;
    stk_rd_addr  = depth_dec2[SAW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          reload_nxt   = 1'b0;
          res_c_nxt    = '0;
          res_row_nxt  = '0;
          res_kind_nxt = gdw_pkg::EV_NONE;
          res_done_nxt = 1'b0;
          if (in_operation == gdw_pkg::OP_START) begin
            if (start_bad) begin
              // bad start abandons any walk
              active_nxt = 1'b0;
              depth_nxt  = '0;
              state_nxt  = S_OUT;
            end else begin
              // push start cell, then sweep the visited rows
              top_c_nxt   = sc_w;
              top_row_nxt = sr_w;
              depth_nxt   = DW'(1);
              active_nxt  = 1'b1;
              stk_wr_en   = 1'b1;
              stk_wr_addr = '0;
              stk_wr_data = {sr_w, sc_w};
              clr_nxt     = '0;
              state_nxt   = S_CLR;
            end
          end else if (active_r && (depth_r != '0)) begin
            // fetch the top cell's own row
            vis_rd_en   = 1'b1;
            vis_rd_addr = top_row_r;
            state_nxt   = S_RD_M;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end

      S_CLR: begin
        // clear one row a cycle, the start row gets the start bit
        vis_wr_en   = 1'b1;
        vis_wr_addr = clr_r;
        if (clr_r == top_row_r) begin
          vis_wr_data = MAX_COLUMNS'(1) << top_c_r;
        end
        clr_nxt = clr_r + RW'(1);
        if (clr_r == RW'(MAX_ROWS - 1)) begin
          res_c_nxt    = 4'(SW'(top_c_r));
          res_row_nxt  = 4'(SW'(top_row_r));
          res_kind_nxt = gdw_pkg::EV_ENTER;
          state_nxt    = S_OUT;
        end
      end

      S_RD_M: begin
        // capture own row, fetch the row above
        row_r_nxt   = vis_rd_data;
        vis_rd_en   = 1'b1;
        vis_rd_addr = ok1 ? r_dec : top_row_r;
        state_nxt   = S_RD_P;
      end

      S_RD_P: begin
        // capture the row above, fetch the row below
        row_m_nxt   = vis_rd_data;
        vis_rd_en   = 1'b1;
        vis_rd_addr = (r8 + SW'(1) < SW'(MAX_ROWS)) ? r_inc : top_row_r;
        state_nxt   = S_DEC;
      end

      S_DEC: begin
        state_nxt = S_OUT;
        if (found) begin
          // enter the first free neighbor
          vis_wr_en    = 1'b1;
          vis_wr_addr  = n_row;
          vis_wr_data  = n_old | (MAX_COLUMNS'(1) << n_c);
          stk_wr_en    = 1'b1;
          depth_nxt    = depth_r + DW'(1);
          top_c_nxt    = n_c;
          top_row_nxt  = n_row;
          res_c_nxt    = 4'(SW'(n_c));
          res_row_nxt  = 4'(SW'(n_row));
          res_kind_nxt = gdw_pkg::EV_ENTER;
          res_done_nxt = 1'b0;
        end else begin
          // leave the top cell, fetch the new top if any
          depth_nxt    = depth_dec;
          res_c_nxt    = 4'(SW'(top_c_r));
          res_row_nxt  = 4'(SW'(top_row_r));
          res_kind_nxt = gdw_pkg::EV_LEAVE;
          if (depth_dec == '0) begin
            active_nxt   = 1'b0;
            res_done_nxt = 1'b1;
          end else begin
            res_done_nxt = 1'b0;
            reload_nxt   = 1'b1;
            stk_rd_en    = 1'b1;
          end
        end
      end

      S_OUT: begin
        // hand the result to the output register
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_c_nxt     = res_c_r;
          out_row_nxt   = res_row_r;
          out_kind_nxt  = res_kind_r;
          out_done_nxt  = res_done_r;
          if (reload_r) begin
            top_c_nxt   = stk_rd_data[CW-1:0];
            top_row_nxt = stk_rd_data[CW+RW-1:CW];
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      reload_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      reload_r    <= reload_nxt;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    clr_r      <= clr_nxt;
    top_c_r    <= top_c_nxt;
    top_row_r  <= top_row_nxt;
    row_r_r    <= row_r_nxt;
    row_m_r    <= row_m_nxt;
    res_c_r    <= res_c_nxt;
    res_row_r  <= res_row_nxt;
    res_kind_r <= res_kind_nxt;
    res_done_r <= res_done_nxt;
    out_c_r    <= out_c_nxt;
    out_row_r  <= out_row_nxt;
    out_kind_r <= out_kind_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_cell_column = out_c_r;
  assign out_cell_row    = out_row_r;
  assign out_event_kind  = out_kind_r;
  assign out_walk_done   = out_done_r;

endmodule

`default_nettype wire

[src/gdw_ram.sv]
`default_nettype none

module gdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/gdw_cfg.sv]
`default_nettype none

module gdw_cfg #(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output gdw_pkg::gdw_sizes_t     sizes
);

  logic [gdw_pkg::CFG_W-1:0]  cols_raw_r;
  logic [gdw_pkg::CFG_W-1:0]  rows_raw_r;
  logic [gdw_pkg::SIZE_W-1:0] cols_ext;
  logic [gdw_pkg::SIZE_W-1:0] rows_ext;
  logic                       wr_beat;

  assign wr_beat = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_raw_r <= gdw_pkg::CFG_RESET;
      rows_raw_r <= gdw_pkg::CFG_RESET;
    end else if (wr_beat) begin
      if (paddr[2] == gdw_pkg::REG_GRID_COLUMNS) begin
        cols_raw_r <= pwdata[gdw_pkg::CFG_W-1:0];
      end
      if (paddr[2] == gdw_pkg::REG_GRID_ROWS) begin
        rows_raw_r <= pwdata[gdw_pkg::CFG_W-1:0];
      end
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    if (paddr[2] == gdw_pkg::REG_GRID_COLUMNS) begin
      prdata[gdw_pkg::CFG_W-1:0] = cols_raw_r;
    end else begin
      prdata[gdw_pkg::CFG_W-1:0] = rows_raw_r;
    end
  end

  // clamp sizes: zero acts as one, above the maximum acts as the maximum
  assign cols_ext = gdw_pkg::SIZE_W'(cols_raw_r);
  assign rows_ext = gdw_pkg::SIZE_W'(rows_raw_r);

  always_comb begin
    if (cols_ext == '0) begin
      sizes.cols = gdw_pkg::SIZE_W'(1);
    end else if (cols_ext > gdw_pkg::SIZE_W'(MAX_COLUMNS)) begin
      sizes.cols = gdw_pkg::SIZE_W'(MAX_COLUMNS);
    end else begin
      sizes.cols = cols_ext;
    end
    if (rows_ext == '0) begin
      sizes.rows = gdw_pkg::SIZE_W'(1);
    end else if (rows_ext > gdw_pkg::SIZE_W'(MAX_ROWS)) begin
      sizes.rows = gdw_pkg::SIZE_W'(MAX_ROWS);
    end else begin
      sizes.rows = rows_ext;
    end
  end

endmodule

`default_nettype wire

[bench/tb_grid_dfs_tree_walker_core.sv]
`default_nettype none

module tb_grid_dfs_tree_walker_core;

  localparam int GRID_MAX_COLUMNS = 16;
  localparam int GRID_MAX_ROWS    = 16;
  localparam int CELL_COUNT       = GRID_MAX_COLUMNS * GRID_MAX_ROWS;
  // a good start sweeps every row of the visited memory
  localparam int SETTLE_CYCLES    = GRID_MAX_ROWS + 4;
  localparam int RANDOM_ITEMS     = 850;

  typedef struct packed {
    logic [3:0] col;
    logic [3:0] row;
    logic [1:0] kind;
    logic       done;
  } walk_event_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic        in_operation    = gdw_pkg::OP_START;
  logic [3:0]  in_start_column = 4'd0;
  logic [3:0]  in_start_row    = 4'd0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [3:0]  out_cell_column;
  logic [3:0]  out_cell_row;
  logic [1:0]  out_event_kind;
  logic        out_walk_done;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = 3'd0;
  logic [31:0] pwdata          = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // walk predictor state
  logic [4:0]  grid_cols_reg;
  logic [4:0]  grid_rows_reg;
  bit          visited_cells [CELL_COUNT];
  logic [3:0]  trail_col [CELL_COUNT];
  logic [3:0]  trail_row [CELL_COUNT];
  int          trail_depth;
  bit          walk_on;

  walk_event_t expected_events [$];
  int          item_count;
  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  grid_dfs_tree_walker_core #(
    .MAX_COLUMNS(GRID_MAX_COLUMNS),
    .MAX_ROWS   (GRID_MAX_ROWS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_start_column(in_start_column),
    .in_start_row   (in_start_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_column(out_cell_column),
    .out_cell_row   (out_cell_row),
    .out_event_kind (out_event_kind),
    .out_walk_done  (out_walk_done),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  // size of zero acts as one, oversize clamps to the maximum
  function automatic int clamp_size(input logic [4:0] raw, input int max_size);
    if (raw == 5'd0) return 1;
    if (int'(raw) > max_size) return max_size;
    return int'(raw);
  endfunction

  function automatic void mark_and_push(input logic [3:0] c, input logic [3:0] r);
    visited_cells[int'(r) * GRID_MAX_COLUMNS + int'(c)] = 1'b1;
    if (trail_depth < CELL_COUNT) begin
      trail_col[trail_depth] = c;
      trail_row[trail_depth] = r;
      trail_depth++;
    end
  endfunction

  // next walk event for one accepted beat, updates the walk state
  function automatic walk_event_t predict_event(input logic op, input logic [3:0] sc,
                                                input logic [3:0] sr);
    int cols;
    int rows;
    int c;
    int r;
    int nc;
    int nr;
    bit ok;
    walk_event_t ev;
    cols = clamp_size(grid_cols_reg, GRID_MAX_COLUMNS);
    rows = clamp_size(grid_rows_reg, GRID_MAX_ROWS);
    ev = '{col: 4'd0, row: 4'd0, kind: gdw_pkg::EV_NONE, done: 1'b0};
    if (op == gdw_pkg::OP_START) begin
      if (int'(sc) >= cols || int'(sr) >= rows) begin
        walk_on = 1'b0;
        trail_depth = 0;
        return ev;
      end
      visited_cells = '{default: 1'b0};
      trail_depth = 0;
      mark_and_push(sc, sr);
      walk_on = 1'b1;
      ev.col = sc;
      ev.row = sr;
      ev.kind = gdw_pkg::EV_ENTER;
      return ev;
    end
    if (!walk_on || trail_depth == 0) return ev;
    c = int'(trail_col[trail_depth - 1]);
    r = int'(trail_row[trail_depth - 1]);
    // neighbor order: +x, -y, -x, +y
    for (int d = 0; d < 4; d++) begin
      nc = c;
      nr = r;
      case (d)
        0: begin
          nc = c + 1;
          ok = nc < cols;
        end
        1: begin
          ok = r > 0;
          nr = r - 1;
        end
        2: begin
          ok = c > 0;
          nc = c - 1;
        end
        default: begin
          nr = r + 1;
          ok = nr < rows;
        end
      endcase
      if (ok && !visited_cells[nr * GRID_MAX_COLUMNS + nc]) begin
        mark_and_push(4'(nc), 4'(nr));
        ev.col = 4'(nc);
        ev.row = 4'(nr);
        ev.kind = gdw_pkg::EV_ENTER;
        return ev;
      end
    end
    // dead end: pop the top cell
    trail_depth--;
    ev.col = 4'(c);
    ev.row = 4'(r);
    ev.kind = gdw_pkg::EV_LEAVE;
    if (trail_depth == 0) begin
      walk_on = 1'b0;
      ev.done = 1'b1;
    end
    return ev;
  endfunction

  // send one input beat, predicting its result on acceptance
  task automatic send_item(input logic op, input logic [3:0] col, input logic [3:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_start_column <= col;
    in_start_row    <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_events.insert(expected_events.size(), predict_event(op, col, row));
    item_count++;
  endtask

  // drop valid and wait until every result is back and the block settles
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write followed by a read-back check
  task automatic write_grid_reg(input logic reg_sel, input logic [4:0] value);
    drain_results();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {27'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == gdw_pkg::REG_GRID_COLUMNS) grid_cols_reg = value;
    else grid_rows_reg = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {27'd0, value})
      report_mismatch($sformatf("register %0d read %0h, wrote %0h", reg_sel, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [4:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 5'($urandom_range(4, 1));
    if (roll < 95) return 5'($urandom_range(8, 5));
    if ($urandom_range(1) == 0) return 5'd0;
    return 5'($urandom_range(31, 16));
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    walk_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected beat col %0d row %0d kind %0d done %0d",
                        out_cell_column, out_cell_row, out_event_kind, out_walk_done));
      end else begin
        want = expected_events.pop_front();
        if (out_cell_column !== want.col || out_cell_row !== want.row ||
            out_event_kind !== want.kind || out_walk_done !== want.done)
          report_mismatch($sformatf("got col %0d row %0d kind %0d done %0d, want %0d %0d %0d %0d",
                          out_cell_column, out_cell_row, out_event_kind, out_walk_done,
                          want.col, want.row, want.kind, want.done));
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // advance with no walk in progress
  task automatic test_idle_advance();
    send_item(gdw_pkg::OP_ADVANCE, 4'hF, 4'hF);
  endtask

  // starts outside the grid, and abandoning a walk
  task automatic test_bad_start();
    send_item(gdw_pkg::OP_START, 4'hF, 4'hF);
    send_item(gdw_pkg::OP_START, 4'd10, 4'd0);
    send_item(gdw_pkg::OP_START, 4'd0, 4'd10);
    send_item(gdw_pkg::OP_START, 4'd9, 4'd9);
    send_item(gdw_pkg::OP_ADVANCE, 4'd0, 4'd0);
    send_item(gdw_pkg::OP_ADVANCE, 4'd0, 4'd0);
    send_item(gdw_pkg::OP_START, 4'd0, 4'hF);
    send_item(gdw_pkg::OP_ADVANCE, 4'd0, 4'd0);
  endtask

  // zero sizes act as a single cell
  task automatic test_single_cell();
    write_grid_reg(gdw_pkg::REG_GRID_COLUMNS, 5'd0);
    write_grid_reg(gdw_pkg::REG_GRID_ROWS, 5'd0);
    send_item(gdw_pkg::OP_START, 4'd0, 4'd0);
    send_item(gdw_pkg::OP_ADVANCE, 4'd0, 4'd0);
    send_item(gdw_pkg::OP_ADVANCE, 4'd0, 4'd0);
  endtask

  // oversize clamps, then the grid shrinks under a walk in progress
  task automatic test_resize_mid_walk();
    write_grid_reg(gdw_pkg::REG_GRID_COLUMNS, 5'd31);
    write_grid_reg(gdw_pkg::REG_GRID_ROWS, 5'd17);
    send_item(gdw_pkg::OP_START, 4'd15, 4'd15);
    send_item(gdw_pkg::OP_ADVANCE, 4'd0, 4'd0);
    write_grid_reg(gdw_pkg::REG_GRID_COLUMNS, 5'd1);
    write_grid_reg(gdw_pkg::REG_GRID_ROWS, 5'd1);
    send_item(gdw_pkg::OP_ADVANCE, 4'd0, 4'd0);
    send_item(gdw_pkg::OP_START, 4'd15, 4'd0);
    send_item(gdw_pkg::OP_ADVANCE, 4'd0, 4'd0);
  endtask

  // full walk of a 2x2 grid from the far corner
  task automatic test_small_walk();
    write_grid_reg(gdw_pkg::REG_GRID_COLUMNS, 5'd2);
    write_grid_reg(gdw_pkg::REG_GRID_ROWS, 5'd2);
    send_item(gdw_pkg::OP_START, 4'd1, 4'd1);
    while (walk_on) send_item(gdw_pkg::OP_ADVANCE, 4'($urandom), 4'($urandom));
  endtask

  // mostly complete walks on random grids, with noise mixed in
  task automatic test_random_walks(input int send_pct, input int stall_pct, input int goal);
    int roll;
    int cols;
    int rows;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    while (item_count < goal) begin
      roll = $urandom_range(99);
      if (roll < 78) begin
        if ($urandom_range(1) == 1) begin
          write_grid_reg(gdw_pkg::REG_GRID_COLUMNS, pick_size());
          write_grid_reg(gdw_pkg::REG_GRID_ROWS, pick_size());
        end
        cols = clamp_size(grid_cols_reg, GRID_MAX_COLUMNS);
        rows = clamp_size(grid_rows_reg, GRID_MAX_ROWS);
        send_item(gdw_pkg::OP_START, 4'($urandom_range(cols - 1)),
                  4'($urandom_range(rows - 1)));
        while (walk_on && item_count < goal) begin
          roll = $urandom_range(99);
          if (roll < 2) begin
            send_item(gdw_pkg::OP_START, 4'($urandom), 4'($urandom));
          end else if (roll < 3) begin
            write_grid_reg(gdw_pkg::REG_GRID_COLUMNS, pick_size());
            write_grid_reg(gdw_pkg::REG_GRID_ROWS, pick_size());
          end else begin
            send_item(gdw_pkg::OP_ADVANCE, 4'($urandom), 4'($urandom));
          end
        end
      end else if (roll < 90) begin
        send_item(gdw_pkg::OP_START, 4'($urandom), 4'($urandom));
      end else begin
        send_item(gdw_pkg::OP_ADVANCE, 4'($urandom), 4'($urandom));
      end
    end
  endtask

  initial begin
    grid_cols_reg  = gdw_pkg::CFG_RESET;
    grid_rows_reg  = gdw_pkg::CFG_RESET;
    trail_depth    = 0;
    walk_on        = 1'b0;
    item_count     = 0;
    error_count    = 0;
    send_idle_pct  = 14;
    recv_stall_pct = 51;
    visited_cells  = '{default: 1'b0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_advance();
    test_bad_start();
    test_single_cell();
    test_resize_mid_walk();
    test_small_walk();

    test_random_walks(14, 51, item_count + RANDOM_ITEMS / 3);
    test_random_walks(51, 14, item_count + RANDOM_ITEMS / 3);
    test_random_walks(0, 0, item_count + RANDOM_ITEMS / 3);

    drain_results();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
